// ----- sv/crt_pkg.sv -----
//------------------------------------------------------------------------------
// CRT merge package
// Shared widths, beat types, sequencer states and unit request types.
//------------------------------------------------------------------------------
`default_nettype none

package crt_pkg;

  localparam int MOD_BITS = 32;
  localparam int W        = MOD_BITS;
  localparam int DW       = 2 * W;
  localparam int SW       = W + 2;
  localparam int CW       = $clog2(DW + 1);

  typedef struct packed {
    logic [31:0] first_modulus;
    logic [31:0] first_residue;
    logic [31:0] second_modulus;
    logic [31:0] second_residue;
  } crt_in_t;

  typedef struct packed {
    logic        solvable;
    logic [63:0] merged_modulus;
    logic [63:0] merged_residue;
  } crt_out_t;

  typedef struct packed {
    logic          start;
    logic          long_op;
    logic [DW-1:0] dvd;
    logic [W-1:0]  dvs;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [DW-1:0] quot;
    logic [W-1:0]  rem;
  } div_res_t;

  typedef struct packed {
    logic         start;
    logic [W-1:0] a;
    logic [W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic          done;
    logic [DW-1:0] prod;
  } mul_res_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_A1, ST_A2, ST_A1M, ST_GCD, ST_DQ, ST_M1R, ST_M2R, ST_LCM,
    ST_EA, ST_EU, ST_EM, ST_INV, ST_KM, ST_KD, ST_XM, ST_FIN
  } crt_state_e;

endpackage

`default_nettype wire

// ----- sv/crt_congruence_merge.sv -----
//------------------------------------------------------------------------------
// CRT congruence merge
// Merges two congruences with non-coprime moduli into one, or flags no solution.
//------------------------------------------------------------------------------
// Run time is data dependent, set by the gcd and Euclid step counts; each step
//   runs the bit-serial divider or multiplier, plus one long division.
// Throughput: one beat per merge; the next beat is taken once the result is held
//   in the output register.
// Reset: asynchronous, active low; clears the sequencer and the output valid.
`default_nettype none

module crt_congruence_merge (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire crt_pkg::crt_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output crt_pkg::crt_out_t     out_data_o
);
  import crt_pkg::*;

  crt_state_e state_q, state_d;
  logic       issued_q, issued_d;
  logic       ovalid_q, ovalid_d;
  crt_out_t   odata_q, odata_d;
  logic       ok_q, ok_d;

  logic [W-1:0]  m1_q, m1_d, r1_q, r1_d, m2_q, m2_d, r2_q, r2_d;
  logic [W-1:0]  a1_q, a1_d, a2_q, a2_d, ga_q, ga_d, gb_q, gb_d, d_q, d_d;
  logic [W-1:0]  del_q, del_d, dq_q, dq_d, m1r_q, m1r_d, m2r_q, m2r_d;
  logic [W-1:0]  ea_q, ea_d, eb_q, eb_d, qq_q, qq_d, inv_q, inv_d, k_q, k_d;
  logic [DW-1:0] lcm_q, lcm_d, kp_q, kp_d, x_q, x_d;
  logic signed [SW-1:0] s0_q, s0_d, s1_q, s1_d, pm;
  logic [SW-1:0] s1_abs;

  div_req_t div_req;
  div_res_t div_res;
  mul_req_t mul_req;
  mul_res_t mul_res;
  logic     use_div, use_mul;

  crt_div u_div (.clk_i, .rst_ni, .req_i(div_req), .res_o(div_res));
  crt_mul u_mul (.clk_i, .rst_ni, .req_i(mul_req), .res_o(mul_res));

  assign s1_abs = s1_q[SW-1] ? SW'(-s1_q) : SW'(s1_q);
  assign pm     = signed'(mul_res.prod[SW-1:0]);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.first_modulus[W-1:0] == '0 ||
              in_data_i.second_modulus[W-1:0] == '0) begin
            state_d = ST_FIN;
          end else begin
            state_d = ST_A1;
          end
        end
      end
      ST_A1:  if (div_res.done) state_d = ST_A2;
      ST_A2:  if (div_res.done) state_d = ST_A1M;
      ST_A1M: if (div_res.done) state_d = ST_GCD;
      ST_GCD: begin
        if (gb_q == '0) begin
          state_d = ST_DQ;
        end else if (div_res.done) begin
          state_d = ST_GCD;
        end
      end
      ST_DQ: begin
        if (div_res.done) begin
          state_d = (div_res.rem != '0) ? ST_FIN : ST_M1R;
        end
      end
      ST_M1R: if (div_res.done) state_d = ST_M2R;
      ST_M2R: if (div_res.done) state_d = ST_LCM;
      ST_LCM: if (mul_res.done) state_d = ST_EA;
      ST_EA:  if (div_res.done) state_d = ST_EU;
      ST_EU: begin
        if (eb_q == '0) begin
          state_d = ST_INV;
        end else if (div_res.done) begin
          state_d = ST_EM;
        end
      end
      ST_EM:  if (mul_res.done) state_d = ST_EU;
      ST_INV: state_d = ST_KM;
      ST_KM:  if (mul_res.done) state_d = ST_KD;
      ST_KD:  if (div_res.done) state_d = ST_XM;
      ST_XM:  if (mul_res.done) state_d = ST_FIN;
      ST_FIN: if (!ovalid_q || !out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    m1_d = m1_q; r1_d = r1_q; m2_d = m2_q; r2_d = r2_q;
    a1_d = a1_q; a2_d = a2_q; ga_d = ga_q; gb_d = gb_q; d_d = d_q;
    del_d = del_q; dq_d = dq_q; m1r_d = m1r_q; m2r_d = m2r_q;
    ea_d = ea_q; eb_d = eb_q; qq_d = qq_q; inv_d = inv_q; k_d = k_q;
    lcm_d = lcm_q; kp_d = kp_q; x_d = x_q; s0_d = s0_q; s1_d = s1_q;
    ok_d = ok_q;
    odata_d = odata_q;
    ovalid_d = ovalid_q && out_stall_i;
    use_div = 1'b0;
    use_mul = 1'b0;
    div_req = '0;
    mul_req = '0;

    case (state_q)
      ST_IDLE: begin
        m1_d = in_data_i.first_modulus[W-1:0];
        r1_d = in_data_i.first_residue[W-1:0];
        m2_d = in_data_i.second_modulus[W-1:0];
        r2_d = in_data_i.second_residue[W-1:0];
        ok_d = 1'b0;
      end
      ST_A1: begin
        use_div = 1'b1;
        div_req.dvd = DW'(r1_q);
        div_req.dvs = m1_q;
        if (div_res.done) a1_d = div_res.rem;
      end
      ST_A2: begin
        use_div = 1'b1;
        div_req.dvd = DW'(r2_q);
        div_req.dvs = m2_q;
        if (div_res.done) a2_d = div_res.rem;
      end
      ST_A1M: begin
        use_div = 1'b1;
        div_req.dvd = DW'(a1_q);
        div_req.dvs = m2_q;
        if (div_res.done) begin
          del_d = (a2_q >= div_res.rem) ? a2_q - div_res.rem
                                        : W'(a2_q + m2_q - div_res.rem);
          ga_d = m1_q;
          gb_d = m2_q;
        end
      end
      ST_GCD: begin
        if (gb_q == '0) begin
          d_d = ga_q;
        end else begin
          use_div = 1'b1;
          div_req.dvd = DW'(ga_q);
          div_req.dvs = gb_q;
          if (div_res.done) begin
            ga_d = gb_q;
            gb_d = div_res.rem;
          end
        end
      end
      ST_DQ: begin
        use_div = 1'b1;
        div_req.dvd = DW'(del_q);
        div_req.dvs = d_q;
        if (div_res.done) dq_d = div_res.quot[W-1:0];
      end
      ST_M1R: begin
        use_div = 1'b1;
        div_req.dvd = DW'(m1_q);
        div_req.dvs = d_q;
        if (div_res.done) m1r_d = div_res.quot[W-1:0];
      end
      ST_M2R: begin
        use_div = 1'b1;
        div_req.dvd = DW'(m2_q);
        div_req.dvs = d_q;
        if (div_res.done) m2r_d = div_res.quot[W-1:0];
      end
      ST_LCM: begin
        use_mul = 1'b1;
        mul_req.a = m1r_q;
        mul_req.b = m2_q;
        if (mul_res.done) lcm_d = mul_res.prod;
      end
      ST_EA: begin
        use_div = 1'b1;
        div_req.dvd = DW'(m1r_q);
        div_req.dvs = m2r_q;
        if (div_res.done) begin
          ea_d = div_res.rem;
          eb_d = m2r_q;
          s0_d = SW'(1);
          s1_d = '0;
        end
      end
      ST_EU: begin
        if (eb_q != '0) begin
          use_div = 1'b1;
          div_req.dvd = DW'(ea_q);
          div_req.dvs = eb_q;
          if (div_res.done) begin
            qq_d = div_res.quot[W-1:0];
            ea_d = eb_q;
            eb_d = div_res.rem;
          end
        end
      end
      ST_EM: begin
        use_mul = 1'b1;
        mul_req.a = qq_q;
        mul_req.b = s1_abs[W-1:0];
        if (mul_res.done) begin
          s0_d = s1_q;
          s1_d = s1_q[SW-1] ? s0_q + pm : s0_q - pm;
        end
      end
      ST_INV: begin
        inv_d = s0_q[SW-1] ? W'(s0_q + signed'(SW'(m2r_q))) : s0_q[W-1:0];
      end
      ST_KM: begin
        use_mul = 1'b1;
        mul_req.a = dq_q;
        mul_req.b = inv_q;
        if (mul_res.done) kp_d = mul_res.prod;
      end
      ST_KD: begin
        use_div = 1'b1;
        div_req.long_op = 1'b1;
        div_req.dvd = kp_q;
        div_req.dvs = m2r_q;
        if (div_res.done) k_d = div_res.rem;
      end
      ST_XM: begin
        use_mul = 1'b1;
        mul_req.a = m1_q;
        mul_req.b = k_q;
        if (mul_res.done) begin
          x_d  = DW'(a1_q) + mul_res.prod;
          ok_d = 1'b1;
        end
      end
      ST_FIN: begin
        if (!ovalid_q || !out_stall_i) begin
          ovalid_d = 1'b1;
          odata_d.solvable       = ok_q;
          odata_d.merged_modulus = ok_q ? 64'(lcm_q) : '0;
          odata_d.merged_residue = ok_q ? 64'(x_q) : '0;
        end
      end
      default: ;
    endcase

    div_req.start = use_div && !issued_q;
    mul_req.start = use_mul && !issued_q;
    if ((use_div || use_mul) && !issued_q) begin
      issued_d = 1'b1;
    end else if (div_res.done || mul_res.done) begin
      issued_d = 1'b0;
    end else begin
      issued_d = issued_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      issued_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m1_q <= m1_d; r1_q <= r1_d; m2_q <= m2_d; r2_q <= r2_d;
    a1_q <= a1_d; a2_q <= a2_d; ga_q <= ga_d; gb_q <= gb_d; d_q <= d_d;
    del_q <= del_d; dq_q <= dq_d; m1r_q <= m1r_d; m2r_q <= m2r_d;
    ea_q <= ea_d; eb_q <= eb_d; qq_q <= qq_d; inv_q <= inv_d; k_q <= k_d;
    lcm_q <= lcm_d; kp_q <= kp_d; x_q <= x_d; s0_q <= s0_d; s1_q <= s1_d;
    ok_q <= ok_d;
    odata_q <= odata_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

endmodule

`default_nettype wire

// ----- sv/crt_div.sv -----
//------------------------------------------------------------------------------
// CRT serial divider
// Restoring divider, one quotient bit per cycle, short or long dividend.
//------------------------------------------------------------------------------
`default_nettype none

module crt_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire crt_pkg::div_req_t req_i,
  output crt_pkg::div_res_t      res_o
);
  import crt_pkg::*;

  logic          busy_q, busy_d, done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] dvd_q, dvd_d, quo_q, quo_d;
  logic [W-1:0]  rem_q, rem_d, dvs_q, dvs_d;
  logic [W:0]    trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, dvd_q[DW-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      dvd_d  = req_i.long_op ? req_i.dvd : {req_i.dvd[W-1:0], {W{1'b0}}};
      cnt_d  = req_i.long_op ? CW'(DW) : CW'(W);
      quo_d  = '0;
      rem_d  = '0;
      dvs_d  = req_i.dvs;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DW-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = W'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign res_o.done = done_q;
  assign res_o.quot = quo_q;
  assign res_o.rem  = rem_q;

endmodule

`default_nettype wire

// ----- sv/crt_mul.sv -----
//------------------------------------------------------------------------------
// CRT serial multiplier
// Shift-add multiplier, one multiplier bit per cycle.
//------------------------------------------------------------------------------
`default_nettype none

module crt_mul (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire crt_pkg::mul_req_t req_i,
  output crt_pkg::mul_res_t      res_o
);
  import crt_pkg::*;

  logic          busy_q, busy_d, done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] a_q, a_d, acc_q, acc_d;
  logic [W-1:0]  b_q, b_d;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      a_d    = DW'(req_i.a);
      b_d    = req_i.b;
      acc_d  = '0;
      cnt_d  = CW'(W);
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_d = acc_q + a_q;
      end
      a_d   = {a_q[DW-2:0], 1'b0};
      b_d   = {1'b0, b_q[W-1:1]};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign res_o.done = done_q;
  assign res_o.prod = acc_q;

endmodule

`default_nettype wire
